### src/sfa_pkg.sv
// shared types and constants of the sprite atlas frame animator
// used by sfa_cfg, sfa_div and the top level; no dependencies
package sfa_pkg;

  localparam logic [19:0] DEFAULT_FRAME_PERIOD_US = 20'd125000;
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  // register indexes on the configuration port
  localparam logic [2:0] REG_GRID_COLUMNS     = 3'd0;
  localparam logic [2:0] REG_GRID_ROWS        = 3'd1;
  localparam logic [2:0] REG_CLIP_FIRST_FRAME = 3'd2;
  localparam logic [2:0] REG_CLIP_FRAME_COUNT = 3'd3;
  localparam logic [2:0] REG_FRAME_PERIOD_US  = 3'd4;
  localparam logic [2:0] REG_CLIP_LOOP        = 3'd5;
  localparam logic [2:0] REG_ATLAS_WIDTH      = 3'd6;
  localparam logic [2:0] REG_ATLAS_HEIGHT     = 3'd7;

  typedef struct packed {
    logic [8:0]  grid_columns;
    logic [8:0]  grid_rows;
    logic [15:0] clip_first_frame;
    logic [11:0] clip_frame_count;
    logic [19:0] frame_period_us;
    logic        clip_loop;
    logic [13:0] atlas_width;
    logic [13:0] atlas_height;
  } cfg_t;

  // divider request: dividend is left aligned, quotient ends in the low steps bits
  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [32:0] dvd;
    logic [31:0] dvs;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
    logic [32:0] quo;
  } div_rsp_t;

endpackage

### src/sfa_cfg.sv
// configuration register file of the sprite atlas frame animator
// depends on sfa_pkg for the register indexes and cfg_t
module sfa_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [19:0]   cfg_data,
  output sfa_pkg::cfg_t cfg
);

  sfa_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns     <= 9'd1;
      cfg_r.grid_rows        <= 9'd1;
      cfg_r.clip_first_frame <= 16'd0;
      cfg_r.clip_frame_count <= 12'd0;
      cfg_r.frame_period_us  <= 20'd0;
      cfg_r.clip_loop        <= 1'b0;
      cfg_r.atlas_width      <= 14'd0;
      cfg_r.atlas_height     <= 14'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfa_pkg::REG_GRID_COLUMNS:     cfg_r.grid_columns     <= cfg_data[8:0];
        sfa_pkg::REG_GRID_ROWS:        cfg_r.grid_rows        <= cfg_data[8:0];
        sfa_pkg::REG_CLIP_FIRST_FRAME: cfg_r.clip_first_frame <= cfg_data[15:0];
        sfa_pkg::REG_CLIP_FRAME_COUNT: cfg_r.clip_frame_count <= cfg_data[11:0];
        sfa_pkg::REG_FRAME_PERIOD_US:  cfg_r.frame_period_us  <= cfg_data;
        sfa_pkg::REG_CLIP_LOOP:        cfg_r.clip_loop        <= cfg_data[0];
        sfa_pkg::REG_ATLAS_WIDTH:      cfg_r.atlas_width      <= cfg_data[13:0];
        sfa_pkg::REG_ATLAS_HEIGHT:     cfg_r.atlas_height     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

### src/sfa_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on sfa_pkg for div_req_t and div_rsp_t
module sfa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sfa_pkg::div_req_t req,
  output sfa_pkg::div_rsp_t rsp
);

  logic [31:0] rem_r, rem_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // partial remainder stays below the divisor, so the shifted value fits 33 bits
  assign trial = {rem_r, quo_r[32]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[31:0] : trial[31:0];
  assign quo_nxt = {quo_r[31:0], ge};

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      quo_r <= req.dvd;
      dvs_r <= req.dvs;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

### src/sprite_atlas_frame_animator.sv
// Sprite sheet animator: each input item adds delta_us to the clip time (restart clears
// it first), wraps or holds it against the clip length, picks the frame and atlas cell and
// returns the cell's texture rectangle as 1.16 fractions, inset by half a texel when both
// atlas sizes are nonzero. One item is worked at a time; in_ready is high only while the
// sequencer is idle. The divisions run on the shared divider, one quotient bit per cycle:
// 33 quotient bits for the looping time wrap, 32 for the frame, 17 each for the cell wrap
// and the column split, and 17 for each of the four coordinates that is not clamped to 0
// or 1.0. An empty clip skips straight to the done state. The sequencer returns to idle
// when the result is registered. The result sits in an output register, so the next item
// is accepted while it waits to be taken; a later result waits until it is.
// Depends on sfa_pkg, sfa_cfg and sfa_div.
module sprite_atlas_frame_animator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_delta_us,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_updated,
  output logic [15:0] out_cell_index,
  output logic [16:0] out_u_left,
  output logic [16:0] out_v_low,
  output logic [16:0] out_u_right,
  output logic [16:0] out_v_high,
  output logic        out_finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_LEN    = 17'h00002,
    S_TSTART = 17'h00004,
    S_TWAIT  = 17'h00008,
    S_FSTART = 17'h00010,
    S_FWAIT  = 17'h00020,
    S_CELLS  = 17'h00040,
    S_LSTART = 17'h00080,
    S_LWAIT  = 17'h00100,
    S_CSTART = 17'h00200,
    S_CWAIT  = 17'h00400,
    S_MDEN   = 17'h00800,
    S_MIDX   = 17'h01000,
    S_NUM    = 17'h02000,
    S_CHK    = 17'h04000,
    S_QWAIT  = 17'h08000,
    S_DONE   = 17'h10000
  } state_t;

  sfa_pkg::cfg_t     cfg;
  sfa_pkg::div_req_t div_req;
  sfa_pkg::div_rsp_t div_rsp;

  state_t state_r, state_nxt;

  logic [31:0] clip_time_r;
  logic [32:0] sum_r;
  logic        empty_r;
  logic [31:0] len_r;
  logic [31:0] t_r;
  logic        fin_r;
  logic [11:0] frame_r;
  logic [17:0] cells_r;
  logic [16:0] lin_r;
  logic [8:0]  col_r;
  logic [8:0]  row_r;
  logic [24:0] den_r;
  logic [23:0] p_r;
  logic signed [25:0] num_r;
  logic        axis_r;
  logic        side_r;
  logic [16:0] coord_r [4];
  logic        out_valid_r;

  logic [19:0] period;
  logic [8:0]  cols_eff;
  logic [8:0]  rows_eff;
  logic        inset;
  logic [8:0]  ax_n;
  logic [8:0]  ax_idx;
  logic [14:0] t2;
  logic [19:0] mul_a;
  logic [11:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] len_m1;
  logic [31:0] t_sat;
  logic [16:0] lin_sum;
  logic signed [25:0] num_nxt;
  logic        num_le0;
  logic        num_ge;
  logic [16:0] frac_q;
  logic        last_coord;
  logic        in_acc;
  logic        out_free;

  sfa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign period   = (cfg.frame_period_us == 20'd0) ? sfa_pkg::DEFAULT_FRAME_PERIOD_US
                                                   : cfg.frame_period_us;
  assign cols_eff = (cfg.grid_columns == 9'd0) ? 9'd1 : cfg.grid_columns;
  assign rows_eff = (cfg.grid_rows == 9'd0) ? 9'd1 : cfg.grid_rows;
  assign inset    = (cfg.atlas_width != 14'd0) && (cfg.atlas_height != 14'd0);

  assign ax_n   = axis_r ? rows_eff : cols_eff;
  assign ax_idx = axis_r ? row_r : col_r;
  assign t2     = axis_r ? {cfg.atlas_height, 1'b0} : {cfg.atlas_width, 1'b0};

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  assign len_m1  = len_r - 32'd1;
  assign t_sat   = (sum_r > {1'b0, len_m1}) ? len_m1 : sum_r[31:0];
  assign lin_sum = {1'b0, cfg.clip_first_frame} + {5'd0, frame_r};

  // shared multiplier: clip length, grid cells, then per axis the denominator and texel offset
  always_comb begin
    mul_a = 20'd0;
    mul_b = 12'd0;
    unique case (state_r)
      S_LEN: begin
        mul_a = period;
        mul_b = cfg.clip_frame_count;
      end
      S_CELLS: begin
        mul_a = {11'd0, cols_eff};
        mul_b = {3'd0, rows_eff};
      end
      S_MDEN: begin
        mul_a = {5'd0, t2};
        mul_b = {3'd0, ax_n};
      end
      S_MIDX: begin
        mul_a = {5'd0, t2};
        mul_b = {3'd0, ax_idx};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // numerator of the current coordinate; the inset moves lo up and hi down by half a texel
  always_comb begin
    if (inset) begin
      if (side_r)
        num_nxt = $signed({2'b00, p_r}) + $signed({11'd0, t2}) - $signed({17'd0, ax_n});
      else
        num_nxt = $signed({2'b00, p_r}) + $signed({17'd0, ax_n});
    end else begin
      if (side_r)
        num_nxt = $signed({17'd0, ax_idx}) + 26'sd1;
      else
        num_nxt = $signed({17'd0, ax_idx});
    end
  end

  assign num_le0 = num_r[25] || (num_r == 26'sd0);
  assign num_ge  = !num_r[25] && (num_r[24:0] >= den_r);
  assign frac_q  = (div_rsp.quo[16:0] > sfa_pkg::FRAC_ONE) ? sfa_pkg::FRAC_ONE
                                                          : div_rsp.quo[16:0];
  assign last_coord = axis_r && side_r;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = 32'd0;
    div_req.dvd      = 33'd0;
    div_req.dvs      = 32'd1;
    div_req.steps    = 6'd1;
    unique case (state_r)
      S_TSTART: begin
        div_req.start = cfg.clip_loop;
        div_req.dvd   = sum_r;
        div_req.dvs   = len_r;
        div_req.steps = 6'd33;
      end
      S_FSTART: begin
        div_req.start = 1'b1;
        div_req.dvd   = {t_r, 1'b0};
        div_req.dvs   = {12'd0, period};
        div_req.steps = 6'd32;
      end
      S_LSTART: begin
        div_req.start = 1'b1;
        div_req.dvd   = {lin_sum, 16'd0};
        div_req.dvs   = {14'd0, cells_r};
        div_req.steps = 6'd17;
      end
      S_CSTART: begin
        div_req.start = 1'b1;
        div_req.dvd   = {lin_r, 16'd0};
        div_req.dvs   = {23'd0, cols_eff};
        div_req.steps = 6'd17;
      end
      S_CHK: begin
        // (num * 2^17 + den) / (2 * den) with the high part preloaded as remainder
        div_req.start    = !num_le0 && !num_ge;
        div_req.rem_init = {7'd0, num_r[24:0]} + {24'd0, den_r[24:17]};
        div_req.dvd      = {den_r[16:0], 16'd0};
        div_req.dvs      = {6'd0, den_r, 1'b0};
        div_req.steps    = 6'd17;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = (cfg.clip_frame_count == 12'd0) ? S_DONE : S_LEN;
      S_LEN:    state_nxt = S_TSTART;
      S_TSTART: state_nxt = cfg.clip_loop ? S_TWAIT : S_FSTART;
      S_TWAIT:  if (div_rsp.done) state_nxt = S_FSTART;
      S_FSTART: state_nxt = S_FWAIT;
      S_FWAIT:  if (div_rsp.done) state_nxt = S_CELLS;
      S_CELLS:  state_nxt = S_LSTART;
      S_LSTART: state_nxt = S_LWAIT;
      S_LWAIT:  if (div_rsp.done) state_nxt = S_CSTART;
      S_CSTART: state_nxt = S_CWAIT;
      S_CWAIT:  if (div_rsp.done) state_nxt = S_MDEN;
      S_MDEN:   state_nxt = S_MIDX;
      S_MIDX:   state_nxt = S_NUM;
      S_NUM:    state_nxt = S_CHK;
      S_CHK: begin
        if (!num_le0 && !num_ge) state_nxt = S_QWAIT;
        else if (last_coord)     state_nxt = S_DONE;
        else if (side_r)         state_nxt = S_MDEN;
        else                     state_nxt = S_NUM;
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          if (last_coord)  state_nxt = S_DONE;
          else if (side_r) state_nxt = S_MDEN;
          else             state_nxt = S_NUM;
        end
      end
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clip_time_r <= 32'd0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      side_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new result loads, otherwise the waiting one holds until taken
      out_valid_r <= ((state_r == S_DONE) && out_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_restart && cfg.clip_frame_count == 12'd0) clip_time_r <= 32'd0;
        end
        S_TSTART: begin
          if (!cfg.clip_loop) clip_time_r <= t_sat;
        end
        S_TWAIT: begin
          if (div_rsp.done) clip_time_r <= div_rsp.rem;
        end
        S_CWAIT: begin
          axis_r <= 1'b0;
          side_r <= 1'b0;
        end
        S_CHK: begin
          if (num_le0 || num_ge) begin
            side_r <= !side_r;
            if (side_r) axis_r <= 1'b1;
          end
        end
        S_QWAIT: begin
          if (div_rsp.done) begin
            side_r <= !side_r;
            if (side_r) axis_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          empty_r <= (cfg.clip_frame_count == 12'd0);
          sum_r   <= {1'b0, (in_restart ? 32'd0 : clip_time_r)} + {13'd0, in_delta_us};
        end
      end
      S_LEN:    len_r <= mul_p;
      S_TSTART: begin
        if (cfg.clip_loop) begin
          fin_r <= 1'b0;
        end else begin
          t_r   <= t_sat;
          fin_r <= (t_sat == len_m1);
        end
      end
      S_TWAIT:  if (div_rsp.done) t_r <= div_rsp.rem;
      S_FWAIT:  if (div_rsp.done) frame_r <= div_rsp.quo[11:0];
      S_CELLS:  cells_r <= mul_p[17:0];
      S_LWAIT:  if (div_rsp.done) lin_r <= div_rsp.rem[16:0];
      S_CWAIT: begin
        if (div_rsp.done) begin
          col_r <= div_rsp.rem[8:0];
          row_r <= div_rsp.quo[8:0];
        end
      end
      S_MDEN:   den_r <= inset ? mul_p[24:0] : {16'd0, ax_n};
      S_MIDX:   p_r <= mul_p[23:0];
      S_NUM:    num_r <= num_nxt;
      S_CHK: begin
        if (num_le0)     coord_r[{axis_r, side_r}] <= 17'd0;
        else if (num_ge) coord_r[{axis_r, side_r}] <= sfa_pkg::FRAC_ONE;
      end
      S_QWAIT:  if (div_rsp.done) coord_r[{axis_r, side_r}] <= frac_q;
      S_DONE: begin
        if (out_free) begin
          out_updated    <= !empty_r;
          out_cell_index <= empty_r ? 16'd0 : lin_r[15:0];
          out_u_left     <= empty_r ? 17'd0 : coord_r[0];
          out_u_right    <= empty_r ? 17'd0 : coord_r[1];
          out_v_low      <= empty_r ? 17'd0 : coord_r[2];
          out_v_high     <= empty_r ? 17'd0 : coord_r[3];
          out_finished   <= empty_r ? 1'b1 : fin_r;
        end
      end
      default: ;
    endcase
  end

endmodule

### dv/tb_top.sv
// testbench for sprite_atlas_frame_animator: random and directed clip ticks against a
// built-in model of clip time, frame pick and cell rectangle, under random stalls
// depends on sfa_pkg and the block's sources
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [19:0] delta;
    logic        restart;
  } tick_t;

  typedef struct packed {
    logic        updated;
    logic [15:0] cell_index;
    logic [16:0] u_left;
    logic [16:0] v_low;
    logic [16:0] u_right;
    logic [16:0] v_high;
    logic        finished;
  } frame_rect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [19:0] in_delta_us = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_updated;
  logic [15:0] out_cell_index;
  logic [16:0] out_u_left;
  logic [16:0] out_v_low;
  logic [16:0] out_u_right;
  logic [16:0] out_v_high;
  logic        out_finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  tick_t         tick_q[$];
  frame_rect_t   rect_q[$];
  tick_t         next_tick;
  sfa_pkg::cfg_t shadow;
  logic [31:0]   clip_time;
  int            errors = 0;
  int            items_made = 0;
  int            items_checked = 0;
  int            in_gap = 0;
  int            out_gap = 0;
  bit            idle_on = 1'b1;

  sprite_atlas_frame_animator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_delta_us    (in_delta_us),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_updated    (out_updated),
    .out_cell_index (out_cell_index),
    .out_u_left     (out_u_left),
    .out_v_low      (out_v_low),
    .out_u_right    (out_u_right),
    .out_v_high     (out_v_high),
    .out_finished   (out_finished),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // round half up into 1.16, clamped to [0, 1.0]
  function automatic logic [16:0] to_fixed16(input longint num, input longint den);
    longint q;
    if (num <= 0) return '0;
    if (num >= den) return sfa_pkg::FRAC_ONE;
    q = (num * 131072 + den) / (2 * den);
    return (q > 65536) ? sfa_pkg::FRAC_ONE : q[16:0];
  endfunction

  function automatic void cell_span(input longint idx, input longint n, input longint tex,
                                    input logic inset, output logic [16:0] lo,
                                    output logic [16:0] hi);
    longint t2;
    longint den;
    if (inset) begin
      t2 = 2 * tex;
      den = t2 * n;
      lo = to_fixed16(t2 * idx + n, den);
      hi = to_fixed16(t2 * (idx + 1) - n, den);
    end else begin
      lo = to_fixed16(idx, n);
      hi = to_fixed16(idx + 1, n);
    end
  endfunction

  function automatic frame_rect_t advance_clip(input logic [19:0] delta, input logic restart);
    frame_rect_t     r;
    longint unsigned period, len, t, frame, cols, rows, cells, linear;
    logic            inset;
    r = '0;
    if (restart) clip_time = '0;
    if (shadow.clip_frame_count == 0) begin
      r.finished = 1'b1;
      return r;
    end
    period = (shadow.frame_period_us != 0) ? shadow.frame_period_us
                                           : sfa_pkg::DEFAULT_FRAME_PERIOD_US;
    len = period * shadow.clip_frame_count;
    // sum kept wide before the wrap or hold
    t = clip_time;
    t = t + delta;
    if (shadow.clip_loop) t = t % len;
    else if (t > len - 1) t = len - 1;
    clip_time = t[31:0];
    frame = t / period;
    if (shadow.clip_loop) frame = frame % shadow.clip_frame_count;
    else if (frame > shadow.clip_frame_count - 1) frame = shadow.clip_frame_count - 1;
    r.finished = !shadow.clip_loop && (t >= len - 1);
    cols = (shadow.grid_columns != 0) ? shadow.grid_columns : 1;
    rows = (shadow.grid_rows != 0) ? shadow.grid_rows : 1;
    cells = cols * rows;
    linear = (shadow.clip_first_frame + frame) % cells;
    inset = (shadow.atlas_width != 0) && (shadow.atlas_height != 0);
    r.updated = 1'b1;
    r.cell_index = linear[15:0];
    cell_span(linear % cols, cols, shadow.atlas_width, inset, r.u_left, r.u_right);
    cell_span(linear / cols, rows, shadow.atlas_height, inset, r.v_low, r.v_high);
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp,
                             input longint unsigned act);
    if (exp != act) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp, act);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rect_q.push_back(advance_clip(in_delta_us, in_restart));
        if (idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 15);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          next_tick = tick_q.pop_front();
          in_valid <= 1'b1;
          in_delta_us <= next_tick.delta;
          in_restart <= next_tick.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    frame_rect_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rect_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending, cell %0d", $time, out_cell_index);
        end else begin
          want = rect_q.pop_front();
          items_checked++;
          check_field("updated", want.updated, out_updated);
          check_field("cell_index", want.cell_index, out_cell_index);
          check_field("u_left", want.u_left, out_u_left);
          check_field("v_low", want.v_low, out_v_low);
          check_field("u_right", want.u_right, out_u_right);
          check_field("v_high", want.v_high, out_v_high);
          check_field("finished", want.finished, out_finished);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 15);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sfa_pkg::REG_GRID_COLUMNS:     shadow.grid_columns = data[8:0];
      sfa_pkg::REG_GRID_ROWS:        shadow.grid_rows = data[8:0];
      sfa_pkg::REG_CLIP_FIRST_FRAME: shadow.clip_first_frame = data[15:0];
      sfa_pkg::REG_CLIP_FRAME_COUNT: shadow.clip_frame_count = data[11:0];
      sfa_pkg::REG_FRAME_PERIOD_US:  shadow.frame_period_us = data;
      sfa_pkg::REG_CLIP_LOOP:        shadow.clip_loop = data[0];
      sfa_pkg::REG_ATLAS_WIDTH:      shadow.atlas_width = data[13:0];
      sfa_pkg::REG_ATLAS_HEIGHT:     shadow.atlas_height = data[13:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [19:0] cols, input logic [19:0] rows,
                       input logic [19:0] first, input logic [19:0] count,
                       input logic [19:0] period, input logic [19:0] loop_on,
                       input logic [19:0] aw, input logic [19:0] ah);
    write_reg(sfa_pkg::REG_GRID_COLUMNS, cols);
    write_reg(sfa_pkg::REG_GRID_ROWS, rows);
    write_reg(sfa_pkg::REG_CLIP_FIRST_FRAME, first);
    write_reg(sfa_pkg::REG_CLIP_FRAME_COUNT, count);
    write_reg(sfa_pkg::REG_FRAME_PERIOD_US, period);
    write_reg(sfa_pkg::REG_CLIP_LOOP, loop_on);
    write_reg(sfa_pkg::REG_ATLAS_WIDTH, aw);
    write_reg(sfa_pkg::REG_ATLAS_HEIGHT, ah);
  endtask

  task automatic push_tick(input logic [19:0] delta, input logic restart);
    tick_t tk;
    tk.delta = delta;
    tk.restart = restart;
    tick_q.push_back(tk);
    items_made++;
  endtask

  // every pushed item has come back as a checked result
  task automatic drain();
    while (items_checked < items_made) @(posedge clk);
  endtask

  function automatic logic [19:0] pick_grid();
    case ($urandom_range(0, 9))
      0: return 20'd0;
      1: return 20'($urandom_range(0, 511));
      2: return 20'd256;
      default: return 20'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [19:0] pick_atlas();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'($urandom_range(0, 16383));
      2: return 20'($urandom_range(1, 4));
      default: return 20'd1 << $urandom_range(4, 13);
    endcase
  endfunction

  task automatic random_setup();
    logic [19:0] val [8];
    val[0] = pick_grid();
    val[1] = pick_grid();
    val[2] = ($urandom_range(0, 4) == 0) ? 20'd0 : 20'($urandom_range(0, 65535));
    case ($urandom_range(0, 11))
      0: val[3] = 20'd0;
      1: val[3] = 20'($urandom_range(0, 4095));
      2: val[3] = 20'd4095;
      default: val[3] = 20'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 7))
      0: val[4] = 20'd0;
      1: val[4] = 20'($urandom_range(0, 1048575));
      2: val[4] = 20'd1048575;
      default: val[4] = 20'($urandom_range(1, 2000));
    endcase
    val[5] = 20'($urandom_range(0, 1));
    val[6] = pick_atlas();
    val[7] = pick_atlas();
    // now and then junk in the bits above the register width
    for (int i = 0; i < 8; i++)
      if ($urandom_range(0, 7) == 0) val[i] = 20'($urandom_range(0, 1048575));
    setup(val[0], val[1], val[2], val[3], val[4], val[5], val[6], val[7]);
  endtask

  initial begin
    int unsigned span;
    int          n;
    shadow = '0;
    shadow.grid_columns = 9'd1;
    shadow.grid_rows = 9'd1;
    clip_time = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: empty clip
    push_tick(20'd1048575, 1'b0);
    push_tick(20'd1048575, 1'b1);
    drain();

    // looping clip on default period
    setup(4, 4, 0, 8, 0, 1, 256, 256);
    push_tick(20'd0, 1'b0);
    push_tick(20'd125000, 1'b0);
    push_tick(20'd124999, 1'b0);
    push_tick(20'd1, 1'b0);
    push_tick(20'd1000000, 1'b0);
    push_tick(20'd0, 1'b1);
    drain();

    // one-shot clip with zero grid sizes, holds on the last frame
    setup(0, 0, 3, 3, 10, 0, 0, 0);
    push_tick(20'd5, 1'b0);
    push_tick(20'd100, 1'b0);
    push_tick(20'd0, 1'b0);
    push_tick(20'd0, 1'b1);
    push_tick(20'd29, 1'b0);
    drain();

    // largest sizes, inset wider than a cell
    setup(511, 511, 65535, 4095, 1048575, 0, 1, 16383);
    push_tick(20'd1048575, 1'b0);
    push_tick(20'd1048575, 1'b0);
    push_tick(20'd0, 1'b1);
    drain();

    // only one atlas size set: no inset
    setup(256, 256, 40000, 1, 1, 1, 0, 8192);
    push_tick(20'd0, 1'b0);
    push_tick(20'd1, 1'b0);
    push_tick(20'd1048575, 1'b1);
    drain();

    // inset of exactly half a cell
    setup(1, 1, 0, 2, 1, 1, 1, 1);
    push_tick(20'd0, 1'b0);
    push_tick(20'd1, 1'b0);
    drain();

    while (items_made < 430) begin
      random_setup();
      idle_on = (items_made < 370);
      span = (shadow.frame_period_us != 0) ? shadow.frame_period_us
                                           : sfa_pkg::DEFAULT_FRAME_PERIOD_US;
      span = span * 2;
      if (span > 1048575) span = 1048575;
      n = $urandom_range(8, 30);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: push_tick(20'd0, $urandom_range(0, 7) == 0);
          1: push_tick(20'($urandom_range(0, 1048575)), $urandom_range(0, 7) == 0);
          2: push_tick(20'd1048575, $urandom_range(0, 7) == 0);
          default: push_tick(20'($urandom_range(0, span)), $urandom_range(0, 7) == 0);
        endcase
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (rect_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, rect_q.size());
    end
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
